@@ rtl/lji_pkg.sv @@
package lji_pkg;

   localparam int unsigned LevelWidth    = 10;
   localparam int unsigned CountWidth    = 32;
   localparam int unsigned DistanceWidth = 16;
   localparam int unsigned CodeWidth     = 3;
   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 16;

   typedef logic [LevelWidth-1:0]    level_type;
   typedef logic [CountWidth-1:0]    count_type;
   typedef logic [DistanceWidth-1:0] distance_type;

   typedef enum logic [CodeWidth-1:0] {
      JT_NONE        = 3'd0,
      JT_LEFT        = 3'd1,
      JT_RIGHT       = 3'd2,
      JT_FRONT_LEFT  = 3'd3,
      JT_FRONT_RIGHT = 3'd4,
      JT_TEE         = 3'd5,
      JT_CROSS       = 3'd6
   } junction_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_FRONT_ON    = 3'd0,
      CSR_FRONT_NEAR  = 3'd1,
      CSR_LEFT_ON     = 3'd2,
      CSR_LEFT_NEAR   = 3'd3,
      CSR_RIGHT_ON    = 3'd4,
      CSR_RIGHT_NEAR  = 3'd5,
      CSR_STABLE_DIST = 3'd6
   } csr_index_type;

   localparam level_type    OnLevelReset   = 10'd600;
   localparam level_type    NearLevelReset = 10'd300;
   localparam distance_type StableReset    = 16'd100;

   typedef struct packed {
      level_type front_on;
      level_type front_near;
      level_type left_on;
      level_type left_near;
      level_type right_on;
      level_type right_near;
   } thresholds_type;

   typedef struct packed {
      logic [CodeWidth-1:0] junction;
      logic [CodeWidth-1:0] candidate;
   } result_type;

endpackage

@@ rtl/lji_classifier.sv @@
module lji_classifier (
   input  lji_pkg::thresholds_type      thresholds,
   input  lji_pkg::level_type           front_level,
   input  lji_pkg::level_type           left_level,
   input  lji_pkg::level_type           right_level,
   output logic [lji_pkg::CodeWidth-1:0] candidate
);
   import lji_pkg::*;

   logic front_active;
   logic left_active;
   logic right_active;

   assign front_active = (front_level >= thresholds.front_on) ||
                         (front_level > thresholds.front_near);
   assign left_active  = (left_level >= thresholds.left_on) ||
                         (left_level > thresholds.left_near);
   assign right_active = (right_level >= thresholds.right_on) ||
                         (right_level > thresholds.right_near);

   always_comb begin
      case ({front_active, left_active, right_active})
         3'b111:  candidate = JT_CROSS;
         3'b011:  candidate = JT_TEE;
         3'b110:  candidate = JT_FRONT_LEFT;
         3'b101:  candidate = JT_FRONT_RIGHT;
         3'b010:  candidate = JT_LEFT;
         3'b001:  candidate = JT_RIGHT;
         default: candidate = JT_NONE;
      endcase
   end

endmodule

@@ rtl/lji_tracker.sv @@
module lji_tracker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [lji_pkg::CodeWidth-1:0] candidate,
   input  lji_pkg::count_type            left_count,
   input  lji_pkg::count_type            right_count,
   input  lji_pkg::distance_type         stable_distance,
   output lji_pkg::result_type           result
);
   import lji_pkg::*;

   logic [CodeWidth-1:0]  held_ff, held_in;
   logic [CodeWidth-1:0]  reported_ff, reported_in;
   count_type             mark_ff, mark_in;
   logic [CountWidth:0]   sum;
   count_type             position;
   logic [CountWidth+1:0] limit;
   logic [CountWidth+1:0] position_ext;
   logic                  moved;

   // The halving rounds toward zero, so a negative odd sum gets one added back.
   assign sum          = {left_count[CountWidth-1], left_count} +
                         {right_count[CountWidth-1], right_count};
   assign position     = sum[CountWidth:1] + {{(CountWidth-1){1'b0}}, sum[CountWidth] & sum[0]};
   assign limit        = {{2{mark_ff[CountWidth-1]}}, mark_ff} +
                         {{(CountWidth+2-DistanceWidth){1'b0}}, stable_distance};
   assign position_ext = {{2{position[CountWidth-1]}}, position};
   assign moved        = $signed(position_ext) > $signed(limit);

   always_comb begin
      held_in     = held_ff;
      reported_in = reported_ff;
      mark_in     = mark_ff;
      if (candidate != held_ff) begin
         reported_in = JT_NONE;
         held_in     = candidate;
         mark_in     = position;
      end else if (moved) begin
         reported_in = candidate;
         mark_in     = position;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff     <= JT_NONE;
         reported_ff <= JT_NONE;
         mark_ff     <= '0;
      end else if (step) begin
         held_ff     <= held_in;
         reported_ff <= reported_in;
         mark_ff     <= mark_in;
      end
   end

   assign result.junction  = reported_in;
   assign result.candidate = candidate;

endmodule

@@ rtl/line_junction_classifier_unit.sv @@
// An accepted beat moves from the input register to the result register, driving rsp_valid.
// Throughput: one beat per cycle unless rsp_ready stalls; the two registers hold one beat each.
// The path from the input register to the result register is the classifier and the tracker.
// Reset is synchronous and active high: it empties both registers, restores the thresholds
// and stable distance to their defaults, and clears the held candidate, mark and report.
module line_junction_classifier_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  lji_pkg::level_type                req_front_level,
   input  lji_pkg::level_type                req_left_level,
   input  lji_pkg::level_type                req_right_level,
   input  lji_pkg::count_type                req_left_count,
   input  lji_pkg::count_type                req_right_count,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [lji_pkg::CodeWidth-1:0]     rsp_junction_type,
   output logic [lji_pkg::CodeWidth-1:0]     rsp_candidate_type,
   input  logic                              csr_wr_en,
   input  logic [lji_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [lji_pkg::CsrDataWidth-1:0]  csr_wdata
);
   import lji_pkg::*;

   thresholds_type       thresholds_ff;
   distance_type         stable_ff;
   logic                 in_valid_ff;
   level_type            front_ff, left_ff, right_ff;
   count_type            left_count_ff, right_count_ff;
   logic                 rsp_valid_ff;
   result_type           rsp_ff;
   result_type           result;
   logic [CodeWidth-1:0] candidate;
   logic                 advance;
   logic                 accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresholds_ff.front_on   <= OnLevelReset;
         thresholds_ff.front_near <= NearLevelReset;
         thresholds_ff.left_on    <= OnLevelReset;
         thresholds_ff.left_near  <= NearLevelReset;
         thresholds_ff.right_on   <= OnLevelReset;
         thresholds_ff.right_near <= NearLevelReset;
         stable_ff                <= StableReset;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_FRONT_ON:    thresholds_ff.front_on   <= csr_wdata[LevelWidth-1:0];
            CSR_FRONT_NEAR:  thresholds_ff.front_near <= csr_wdata[LevelWidth-1:0];
            CSR_LEFT_ON:     thresholds_ff.left_on    <= csr_wdata[LevelWidth-1:0];
            CSR_LEFT_NEAR:   thresholds_ff.left_near  <= csr_wdata[LevelWidth-1:0];
            CSR_RIGHT_ON:    thresholds_ff.right_on   <= csr_wdata[LevelWidth-1:0];
            CSR_RIGHT_NEAR:  thresholds_ff.right_near <= csr_wdata[LevelWidth-1:0];
            CSR_STABLE_DIST: stable_ff                <= csr_wdata[DistanceWidth-1:0];
            default: begin
            end
         endcase
      end
   end

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         front_ff       <= req_front_level;
         left_ff        <= req_left_level;
         right_ff       <= req_right_level;
         left_count_ff  <= req_left_count;
         right_count_ff <= req_right_count;
      end
   end

   lji_classifier u_classifier (
      .thresholds  (thresholds_ff),
      .front_level (front_ff),
      .left_level  (left_ff),
      .right_level (right_ff),
      .candidate   (candidate)
   );

   lji_tracker u_tracker (
      .clock           (clock),
      .reset           (reset),
      .step            (advance),
      .candidate       (candidate),
      .left_count      (left_count_ff),
      .right_count     (right_count_ff),
      .stable_distance (stable_ff),
      .result          (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_junction_type  = rsp_ff.junction;
   assign rsp_candidate_type = rsp_ff.candidate;

   // A reported junction is always the candidate that is being held.
   a_report_matches_candidate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.junction != JT_NONE) |-> rsp_ff.junction == rsp_ff.candidate)
      else $error("reported junction differs from candidate");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !in_valid_ff && !rsp_valid_ff)
      else $error("pipeline not empty after reset");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      accept |=> in_valid_ff)
      else $error("accepted beat lost from input register");

   a_stalled_input_holds: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(left_count_ff) && $stable(front_ff))
      else $error("stalled input register changed");

   a_stalled_result_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("stalled result register changed");

endmodule

@@ tb/junction_track_checker.sv @@
module junction_track_checker
   import lji_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  level_type                req_front_level,
   input  level_type                req_left_level,
   input  level_type                req_right_level,
   input  count_type                req_left_count,
   input  count_type                req_right_count,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic [CodeWidth-1:0]     rsp_junction_type,
   input  logic [CodeWidth-1:0]     rsp_candidate_type,
   input  logic                     csr_wr_en,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata,
   output int                       mismatches,
   output int                       outstanding,
   output int                       results_checked
);

   thresholds_type levels_cfg;
   distance_type   stable_cfg;
   junction_type   held_kind;
   longint         mark_pos;
   junction_type   shown_kind;
   result_type     expected_types[$];

   initial begin
      mismatches      = 0;
      outstanding     = 0;
      results_checked = 0;
   end

   function automatic bit sensor_on(level_type lvl, level_type on_lvl, level_type near_lvl);
      return (lvl >= on_lvl) || (lvl > near_lvl);
   endfunction

   function automatic junction_type classify(level_type f, level_type l, level_type r);
      bit           fa;
      bit           la;
      bit           ra;
      junction_type kind;
      fa = sensor_on(f, levels_cfg.front_on, levels_cfg.front_near);
      la = sensor_on(l, levels_cfg.left_on, levels_cfg.left_near);
      ra = sensor_on(r, levels_cfg.right_on, levels_cfg.right_near);
      kind = JT_NONE;
      if (la) begin
         kind = JT_LEFT;
      end else if (ra) begin
         kind = JT_RIGHT;
      end
      if (fa && la) begin
         kind = JT_FRONT_LEFT;
      end else if (fa && ra) begin
         kind = JT_FRONT_RIGHT;
      end
      if (la && ra) begin
         kind = JT_TEE;
      end
      if (fa && la && ra) begin
         kind = JT_CROSS;
      end
      return kind;
   endfunction

   // Advances the held candidate, mark and reported type by one beat.
   function automatic result_type track_beat(level_type f, level_type l, level_type r,
                                             count_type lc, count_type rc);
      junction_type kind;
      longint       pos;
      result_type   res;
      kind = classify(f, l, r);
      pos  = (longint'($signed(lc)) + longint'($signed(rc))) / 2;
      if (kind != held_kind) begin
         shown_kind = JT_NONE;
         held_kind  = kind;
         mark_pos   = pos;
      end else if (pos > mark_pos + longint'(stable_cfg)) begin
         shown_kind = kind;
         mark_pos   = pos;
      end
      res.junction  = shown_kind;
      res.candidate = kind;
      return res;
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         levels_cfg.front_on   = OnLevelReset;
         levels_cfg.front_near = NearLevelReset;
         levels_cfg.left_on    = OnLevelReset;
         levels_cfg.left_near  = NearLevelReset;
         levels_cfg.right_on   = OnLevelReset;
         levels_cfg.right_near = NearLevelReset;
         stable_cfg            = StableReset;
         held_kind             = JT_NONE;
         mark_pos              = 0;
         shown_kind            = JT_NONE;
         expected_types.delete();
         outstanding <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_checked++;
            if (expected_types.size() == 0) begin
               mismatches++;
               $display("%0t: result beat with nothing expected, actual junction %0d candidate %0d",
                        $time, rsp_junction_type, rsp_candidate_type);
            end else begin
               want = expected_types.pop_front();
               if (rsp_junction_type !== want.junction) begin
                  mismatches++;
                  $display("%0t: junction_type expected %0d actual %0d",
                           $time, want.junction, rsp_junction_type);
               end
               if (rsp_candidate_type !== want.candidate) begin
                  mismatches++;
                  $display("%0t: candidate_type expected %0d actual %0d",
                           $time, want.candidate, rsp_candidate_type);
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_types.push_back(track_beat(req_front_level, req_left_level,
                                                req_right_level, req_left_count,
                                                req_right_count));
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_FRONT_ON:    levels_cfg.front_on   = level_type'(csr_wdata);
               CSR_FRONT_NEAR:  levels_cfg.front_near = level_type'(csr_wdata);
               CSR_LEFT_ON:     levels_cfg.left_on    = level_type'(csr_wdata);
               CSR_LEFT_NEAR:   levels_cfg.left_near  = level_type'(csr_wdata);
               CSR_RIGHT_ON:    levels_cfg.right_on   = level_type'(csr_wdata);
               CSR_RIGHT_NEAR:  levels_cfg.right_near = level_type'(csr_wdata);
               CSR_STABLE_DIST: stable_cfg            = csr_wdata;
               default: begin
               end
            endcase
         end
         outstanding <= expected_types.size();
      end
   end

endmodule

@@ tb/tb.sv @@
module tb;
   import lji_pkg::*;

   localparam logic [CsrIndexWidth-1:0] CsrBeyondList = 3'd7;
   localparam count_type CountMax = 32'h7FFF_FFFF;
   localparam count_type CountMin = 32'h8000_0000;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   level_type                req_front_level = '0;
   level_type                req_left_level = '0;
   level_type                req_right_level = '0;
   count_type                req_left_count = '0;
   count_type                req_right_count = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [CodeWidth-1:0]     rsp_junction_type;
   logic [CodeWidth-1:0]     rsp_candidate_type;
   logic                     csr_wr_en = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0]  csr_wdata = '0;

   int mismatches;
   int outstanding;
   int results_checked;

   int req_idle_pct = 17;
   int rsp_idle_pct = 85;
   int beats_sent = 0;
   int settings_count = 0;

   int on_lvl[3];
   int near_lvl[3];
   int stable_ticks;

   always #1 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   line_junction_classifier_unit u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_front_level    (req_front_level),
      .req_left_level     (req_left_level),
      .req_right_level    (req_right_level),
      .req_left_count     (req_left_count),
      .req_right_count    (req_right_count),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_junction_type  (rsp_junction_type),
      .rsp_candidate_type (rsp_candidate_type),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   junction_track_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_front_level    (req_front_level),
      .req_left_level     (req_left_level),
      .req_right_level    (req_right_level),
      .req_left_count     (req_left_count),
      .req_right_count    (req_right_count),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_junction_type  (rsp_junction_type),
      .rsp_candidate_type (rsp_candidate_type),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .mismatches         (mismatches),
      .outstanding        (outstanding),
      .results_checked    (results_checked)
   );

   task automatic send_beat(level_type f, level_type l, level_type r,
                            count_type lc, count_type rc);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_front_level <= f;
      req_left_level  <= l;
      req_right_level <= r;
      req_left_count  <= lc;
      req_right_count <= rc;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      beats_sent++;
   endtask

   // Holds the sender off until every expected result beat has come back.
   task automatic drain();
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (outstanding != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_write(logic [CsrIndexWidth-1:0] idx, logic [CsrDataWidth-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic write_settings();
      csr_write(CSR_FRONT_ON,    {6'($urandom), level_type'(on_lvl[0])});
      csr_write(CSR_FRONT_NEAR,  {6'($urandom), level_type'(near_lvl[0])});
      csr_write(CSR_LEFT_ON,     {6'($urandom), level_type'(on_lvl[1])});
      csr_write(CSR_LEFT_NEAR,   {6'($urandom), level_type'(near_lvl[1])});
      csr_write(CSR_RIGHT_ON,    {6'($urandom), level_type'(on_lvl[2])});
      csr_write(CSR_RIGHT_NEAR,  {6'($urandom), level_type'(near_lvl[2])});
      csr_write(CSR_STABLE_DIST, distance_type'(stable_ticks));
      csr_write(CsrBeyondList,   16'($urandom));
      csr_wr_en <= 1'b0;
      settings_count++;
   endtask

   task automatic choose_settings(int kind);
      for (int s = 0; s < 3; s++) begin
         case (kind)
            0: begin
               on_lvl[s]   = $urandom_range(1023);
               near_lvl[s] = $urandom_range(1023);
            end
            1: begin
               on_lvl[s]   = 0;
               near_lvl[s] = 0;
            end
            2: begin
               on_lvl[s]   = 1023;
               near_lvl[s] = 1023;
            end
            3: begin
               on_lvl[s]   = $urandom_range(600);
               near_lvl[s] = $urandom_range(1023, on_lvl[s]);
            end
            4: begin
               near_lvl[s] = $urandom_range(700);
               on_lvl[s]   = $urandom_range(1023, near_lvl[s]);
            end
            default: begin
               on_lvl[s]   = 600;
               near_lvl[s] = 300;
            end
         endcase
      end
      case (kind)
         0:       stable_ticks = $urandom_range(300);
         1:       stable_ticks = 0;
         2:       stable_ticks = 65535;
         4:       stable_ticks = $urandom_range(65535);
         default: stable_ticks = 100;
      endcase
   endtask

   function automatic level_type pick_level(int s);
      case ($urandom_range(6))
         0:       return '0;
         1:       return '1;
         2:       return level_type'(on_lvl[s]);
         3:       return level_type'(on_lvl[s] - 1);
         4:       return level_type'(near_lvl[s]);
         5:       return level_type'(near_lvl[s] + 1);
         default: return level_type'($urandom);
      endcase
   endfunction

   // Mostly runs of one sensor pattern while the position creeps forward, so that
   // candidates persist long enough to be reported; the rest is unrelated noise.
   task automatic run_segment(int count);
      int        done;
      int        run_len;
      longint    pos;
      longint    spread;
      level_type f;
      level_type l;
      level_type r;
      done = 0;
      pos  = 0;
      while (done < count) begin
         if ($urandom_range(99) < 15) begin
            send_beat(level_type'($urandom), level_type'($urandom), level_type'($urandom),
                      count_type'($urandom), count_type'($urandom));
            done++;
         end else begin
            if ($urandom_range(3) == 0) begin
               pos = longint'($signed(count_type'($urandom)));
            end
            f = pick_level(0);
            l = pick_level(1);
            r = pick_level(2);
            run_len = $urandom_range(10, 1);
            for (int k = 0; k < run_len && done < count; k++) begin
               case ($urandom_range(3))
                  0:       pos = pos + $urandom_range(stable_ticks);
                  1:       pos = pos + stable_ticks + 1 + $urandom_range(stable_ticks);
                  2:       pos = pos - $urandom_range(500);
                  default: pos = pos + stable_ticks + $urandom_range(1);
               endcase
               spread = $urandom_range(1000);
               send_beat(f, l, r, count_type'(pos + spread + $urandom_range(1)),
                         count_type'(pos - spread));
               done++;
            end
            if ($urandom_range(49) == 0) begin
               drain();
            end
         end
      end
   endtask

   initial begin
      #400000;
      $display("tb failed");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      choose_settings(5);

      send_beat(0, 0, 0, 0, 0);
      send_beat(0, 600, 0, 0, 0);
      send_beat(0, 600, 0, 202, 0);
      send_beat(0, 0, 301, 0, 0);
      send_beat(1023, 1023, 0, 0, 0);
      send_beat(599, 0, 599, 0, 0);
      send_beat(0, 301, 1023, 0, 0);
      send_beat(300, 300, 300, 0, 0);
      send_beat(1023, 1023, 1023, CountMax, CountMax);
      send_beat(1023, 1023, 1023, CountMax, CountMax);
      send_beat(1023, 0, 0, CountMin, CountMin);
      send_beat(1023, 0, 0, CountMin, CountMax);
      send_beat(0, 0, 0, -3, 0);
      send_beat(0, 700, 0, 0, 0);
      send_beat(0, 700, 0, 200, 0);
      send_beat(0, 700, 0, 201, 0);
      send_beat(0, 700, 0, 202, 0);
      send_beat(0, 700, 0, -500, -500);
      send_beat(1023, 1023, 1023, 32'hAAAA_AAAA, 32'h5555_5555);
      send_beat(1023, 1023, 1023, 32'h5555_5555, 32'hAAAA_AAAA);

      for (int seg = 0; seg < 12; seg++) begin
         drain();
         choose_settings(seg % 6);
         write_settings();
         if (seg == 4) begin
            req_idle_pct = 85;
            rsp_idle_pct = 17;
         end else if (seg == 8) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         run_segment(50);
      end

      drain();
      $display("Run covered %0d request beats over %0d register settings, %0d results checked.",
               beats_sent, settings_count, results_checked);
      $display("Settings included all-zero and all-max thresholds, empty near bands and stable distances 0 and 65535.");
      if (mismatches == 0 && outstanding == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/lji_pkg.sv
rtl/lji_classifier.sv
rtl/lji_tracker.sv
rtl/line_junction_classifier_unit.sv
tb/junction_track_checker.sv
tb/tb.sv
